/* hdl/fsba_pkg.sv */
package fsba_pkg;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE    = 2'd1;
    localparam logic [1:0] STATUS_TABLE_FULL  = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND   = 2'd3;

    localparam logic [2:0] STRAT_FIRST_FIT    = 3'd0;
    localparam logic [2:0] STRAT_BEST_FIT     = 3'd1;
    localparam logic [2:0] STRAT_WORST_FIT    = 3'd2;
    localparam logic [2:0] STRAT_NEXT_FIT     = 3'd3;
    localparam logic [2:0] STRAT_ALWAYS_GROW  = 3'd4;

    localparam logic       ACTION_ALLOC       = 1'b0;
    localparam logic       ACTION_FREE        = 1'b1;

endpackage

/* hdl/fit_strategy_block_allocator_unit.sv */
// Heap allocator over an address-ordered linked list of block headers held in
// a single-port-write, registered-read header memory. An allocate or free walks
// the list one header per cycle, over at most MAX_BLOCKS headers; an allocate
// also waits for the free-slot scan, which checks one slot per cycle and starts
// with the item. Next fit and always grow read only the tail header. After
// reset the block writes the head header in its init state and holds busy
// meanwhile. Each item gives exactly one result, shown for one cycle with
// o_result_valid; there is no backpressure on results. The strategy write is
// held off (o_cfg_ready low) while busy is high.
module fit_strategy_block_allocator_unit
    import fsba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_free_address,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_block_address,
    output logic [16:0] o_bytes_in_use
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = $clog2(HEAP_BYTES + 1);
    localparam int NW = ((AW > 16) ? AW : 16) + 2;
    localparam logic [SW-1:0] END_MARK = SW'(MAX_BLOCKS);
    localparam logic [NW-1:0] HDR_N    = NW'(HEADER_BYTES);
    localparam logic [AW-1:0] HEAD_FREE = AW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [NW-1:0] SAT_N    = NW'(131071);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_FREE = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_WR2  = 3'd5;

    typedef struct packed {
        logic [AW-1:0] offset;
        logic [15:0]   used;
        logic [AW-1:0] trail;
        logic [SW-1:0] succ;
    } t_entry;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_q;

    logic [2:0]            r_state;
    logic [2:0]            r_strategy;
    logic [15:0]           r_size;
    logic [15:0]           r_addr;
    logic [IW-1:0]         r_cur;
    logic [IW-1:0]         r_prev;
    t_entry                r_pe;
    logic [IW-1:0]         r_ch;
    t_entry                r_ce;
    logic [AW-1:0]         r_best;
    logic                  r_found;
    logic                  r_first;
    logic [SW-1:0]         r_k;
    logic                  r_kfound;
    logic [MAX_BLOCKS-1:0] r_in_use;
    logic [IW-1:0]         r_tail;
    logic [AW-1:0]         r_used;
    logic                  r_res_valid;
    logic [1:0]            r_res_status;
    logic [15:0]           r_res_addr;

    logic                  accept;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    t_entry                wr_data;
    logic [NW-1:0]         need;
    logic [NW-1:0]         q_trail_n;
    logic                  fits;
    logic [AW-1:0]         left;
    logic                  take;
    logic                  tail_mode;
    logic                  walk_stop;
    logic                  match;
    logic                  q_end;
    logic [NW-1:0]         new_off;
    logic [NW-1:0]         new_addr;
    logic [NW-1:0]         merged;
    logic [NW-1:0]         used_n;
    logic                  scan_done;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    assign need      = HDR_N + NW'(r_size);
    assign q_trail_n = NW'(r_q.trail);
    assign fits      = (q_trail_n >= need);
    assign left      = AW'(q_trail_n - need);
    assign tail_mode = (r_strategy == STRAT_NEXT_FIT) || (r_strategy == STRAT_ALWAYS_GROW);
    assign take      = fits && (!r_found
                       || ((r_strategy == STRAT_BEST_FIT) && (left < r_best))
                       || ((r_strategy == STRAT_WORST_FIT) && (left > r_best)));
    assign q_end     = (r_q.succ == END_MARK);
    assign walk_stop = (fits && (r_strategy == STRAT_FIRST_FIT)) || tail_mode || q_end;
    assign match     = ((NW'(r_q.offset) + HDR_N) == NW'(r_addr));
    assign new_off   = NW'(r_ce.offset) + HDR_N + NW'(r_ce.used);
    assign new_addr  = new_off + HDR_N;
    assign merged    = NW'(r_pe.trail) + NW'(r_q.trail) + NW'(r_q.used) + HDR_N;
    assign scan_done = r_kfound || (r_k == END_MARK);
    assign used_n    = NW'(r_used);

    always_comb begin
        rd_addr = '0;
        if (r_state == S_IDLE) begin
            if ((i_action == ACTION_ALLOC) && tail_mode) begin
                rd_addr = r_tail;
            end
        end else if (r_state == S_WALK || r_state == S_FREE) begin
            rd_addr = r_q.succ[IW-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        case (r_state)
            S_INIT: begin
                wr_en         = 1'b1;
                wr_data.trail = HEAD_FREE;
                wr_data.succ  = END_MARK;
            end
            S_FIN: begin
                if (r_found && scan_done && r_kfound) begin
                    wr_en          = 1'b1;
                    wr_addr        = r_k[IW-1:0];
                    wr_data.offset = AW'(new_off);
                    wr_data.used   = r_size;
                    wr_data.trail  = AW'(NW'(r_ce.trail) - need);
                    wr_data.succ   = r_ce.succ;
                end
            end
            S_WR2: begin
                wr_en          = 1'b1;
                wr_addr        = r_ch;
                wr_data.offset = r_ce.offset;
                wr_data.used   = r_ce.used;
                wr_data.trail  = '0;
                wr_data.succ   = r_k;
            end
            S_FREE: begin
                if (!r_first && match) begin
                    wr_en          = 1'b1;
                    wr_addr        = r_prev;
                    wr_data.offset = r_pe.offset;
                    wr_data.used   = r_pe.used;
                    wr_data.trail  = AW'(merged);
                    wr_data.succ   = r_q.succ;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_strategy  <= STRAT_FIRST_FIT;
            r_in_use    <= MAX_BLOCKS'(1);
            r_tail      <= '0;
            r_used      <= '0;
            r_res_valid <= 1'b0;
            r_found     <= 1'b0;
            r_kfound    <= 1'b0;
            r_first     <= 1'b0;
            r_k         <= '0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_strategy <= i_cfg_data;
            end
            if ((r_state == S_WALK || r_state == S_FIN) && !scan_done) begin
                if (!r_in_use[r_k[IW-1:0]]) begin
                    r_kfound <= 1'b1;
                end else begin
                    r_k <= r_k + SW'(1);
                end
            end
            case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_size   <= i_request_size;
                        r_addr   <= i_free_address;
                        r_found  <= 1'b0;
                        r_kfound <= 1'b0;
                        r_k      <= SW'(1);
                        r_first  <= 1'b1;
                        r_cur    <= (i_action == ACTION_ALLOC && tail_mode) ? r_tail : '0;
                        if (i_action == ACTION_FREE) begin
                            r_state <= S_FREE;
                        end else if (r_strategy > STRAT_ALWAYS_GROW) begin
                            r_res_valid  <= 1'b1;
                            r_res_status <= STATUS_NO_SPACE;
                            r_res_addr   <= '0;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (take) begin
                        r_ch    <= r_cur;
                        r_ce    <= r_q;
                        r_best  <= left;
                        r_found <= 1'b1;
                    end
                    if (walk_stop) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cur <= r_q.succ[IW-1:0];
                    end
                end
                S_FIN: begin
                    if (!r_found) begin
                        r_res_valid  <= 1'b1;
                        r_res_status <= STATUS_NO_SPACE;
                        r_res_addr   <= '0;
                        r_state      <= S_IDLE;
                    end else if (scan_done) begin
                        if (!r_kfound) begin
                            r_res_valid  <= 1'b1;
                            r_res_status <= STATUS_TABLE_FULL;
                            r_res_addr   <= '0;
                            r_state      <= S_IDLE;
                        end else begin
                            r_in_use[r_k[IW-1:0]] <= 1'b1;
                            if (r_ce.succ == END_MARK) begin
                                r_tail <= r_k[IW-1:0];
                            end
                            r_res_addr <= new_addr[15:0];
                            r_state    <= S_WR2;
                        end
                    end
                end
                S_WR2: begin
                    r_used       <= r_used + AW'(r_size);
                    r_res_valid  <= 1'b1;
                    r_res_status <= STATUS_OK;
                    r_state      <= S_IDLE;
                end
                S_FREE: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_prev  <= '0;
                        r_pe    <= r_q;
                        r_cur   <= r_q.succ[IW-1:0];
                        if (q_end) begin
                            r_res_valid  <= 1'b1;
                            r_res_status <= STATUS_NOT_FOUND;
                            r_res_addr   <= '0;
                            r_state      <= S_IDLE;
                        end
                    end else if (match) begin
                        if (r_tail == r_cur) begin
                            r_tail <= r_prev;
                        end
                        r_used          <= r_used - AW'(r_q.used);
                        r_in_use[r_cur] <= 1'b0;
                        r_res_valid     <= 1'b1;
                        r_res_status    <= STATUS_OK;
                        r_res_addr      <= '0;
                        r_state         <= S_IDLE;
                    end else begin
                        r_prev <= r_cur;
                        r_pe   <= r_q;
                        r_cur  <= r_q.succ[IW-1:0];
                        if (q_end) begin
                            r_res_valid  <= 1'b1;
                            r_res_status <= STATUS_NOT_FOUND;
                            r_res_addr   <= '0;
                            r_state      <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid  = r_res_valid;
    assign o_status        = r_res_status;
    assign o_block_address = r_res_addr;
    assign o_bytes_in_use  = (used_n > SAT_N) ? 17'h1FFFF : used_n[16:0];

endmodule
